// ----- rtl/core/bqb_pkg.sv -----
// Shared constants, codes and types for the biquad bank.
`timescale 1ns / 1ps
package bqb_pkg;

  localparam int MAX_SECTIONS_DEF = 64;
  localparam int MAX_CHANNELS_DEF = 8;
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS = 24;
  localparam int STATE_BITS = 32;
  localparam int COEF_FRAC = COEF_BITS - 4;
  localparam int PROD_BITS = COEF_BITS + STATE_BITS;
  localparam int TERM_BITS = PROD_BITS - COEF_FRAC;
  localparam int WACC_BITS = TERM_BITS + 2;

  localparam logic CMD_PROCESS = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [2:0] SEL_A0 = 3'd0;
  localparam logic [2:0] SEL_A1 = 3'd1;
  localparam logic [2:0] SEL_A2 = 3'd2;
  localparam logic [2:0] SEL_B1 = 3'd3;
  localparam logic [2:0] SEL_B2 = 3'd4;

  localparam logic REG_SECTIONS = 1'b0;
  localparam logic REG_CHANNELS = 1'b1;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_B1D1,
    MUL_B2D2,
    MUL_A0W,
    MUL_A1D1,
    MUL_A2D2
  } mul_op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FB1,
    ST_FB2,
    ST_FBW,
    ST_WSAT,
    ST_FF0,
    ST_FF1,
    ST_FF2,
    ST_UPD,
    ST_OLOAD,
    ST_OWAIT
  } state_t;

  typedef struct packed {
    logic    clr;
    logic    start;
    logic    wr_coef;
    logic    rd_sec;
    mul_op_t mul_op;
    logic    wsat;
    logic    ff_rd;
    logic    upd;
    logic    out_load;
    logic    out_last;
  } dp_cmd_t;

endpackage

// ----- rtl/core/bqb_datapath.sv -----
// Datapath: coefficient and state memories, shared multiplier, accumulators.
`timescale 1ns / 1ps
module bqb_datapath
  import bqb_pkg::*;
#(
  parameter int MAX_SECTIONS = MAX_SECTIONS_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  localparam int SW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1,
  localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int FF_DEPTH = MAX_SECTIONS * MAX_CHANNELS,
  localparam int FW = (FF_DEPTH > 1) ? $clog2(FF_DEPTH) : 1
) (
  input  logic                          clk,
  input  dp_cmd_t                       cmd,
  input  logic [FW-1:0]                 clr_idx,
  input  logic [SW-1:0]                 sec_idx,
  input  logic [CW-1:0]                 ch_idx,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic [2:0]                    in_coef_select,
  input  logic [5:0]                    in_section_index,
  input  logic [2:0]                    in_channel_index,
  input  logic signed [COEF_BITS-1:0]   in_coef_value,
  output logic [2:0]                    out_channel,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_last_channel
);

  localparam int ACC_BITS = TERM_BITS + $clog2(3 * MAX_SECTIONS) + 1;
  localparam logic signed [PROD_BITS-1:0] HALF = PROD_BITS'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [WACC_BITS-1:0] W_MAX =
    {{(WACC_BITS-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [WACC_BITS-1:0] W_MIN = ~W_MAX;
  localparam logic signed [ACC_BITS-1:0] Y_MAX =
    {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] Y_MIN = ~Y_MAX;

  logic signed [COEF_BITS-1:0] ff0_mem [FF_DEPTH];
  logic signed [COEF_BITS-1:0] ff1_mem [FF_DEPTH];
  logic signed [COEF_BITS-1:0] ff2_mem [FF_DEPTH];
  logic signed [COEF_BITS-1:0] fb1_mem [MAX_SECTIONS];
  logic signed [COEF_BITS-1:0] fb2_mem [MAX_SECTIONS];
  logic signed [STATE_BITS-1:0] d1_mem [MAX_SECTIONS];
  logic signed [STATE_BITS-1:0] d2_mem [MAX_SECTIONS];

  logic signed [COEF_BITS-1:0]   a0_r, a1_r, a2_r, b1_r, b2_r;
  logic signed [STATE_BITS-1:0]  d1_r, d2_r, w_r;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [WACC_BITS-1:0]   wacc_r;
  logic signed [PROD_BITS-1:0]   prod_r;
  mul_op_t                       pop_r;
  logic [CW-1:0]                 ffch_r, pch_r;
  logic signed [ACC_BITS-1:0]    acc_r [MAX_CHANNELS];
  logic [2:0]                    out_channel_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_last_r;

  logic signed [COEF_BITS-1:0]  mul_a;
  logic signed [STATE_BITS-1:0] mul_b;
  logic signed [PROD_BITS-1:0]  rnd;
  logic signed [TERM_BITS-1:0]  term;
  logic                         sec_ok, ch_ok, clr_low;
  logic [SW-1:0]                wsec;
  logic [FW-1:0]                wff_addr, rff_addr;

  assign sec_ok = 32'(in_section_index) < MAX_SECTIONS;
  assign ch_ok = 32'(in_channel_index) < MAX_CHANNELS;
  assign wsec = SW'(in_section_index);
  assign wff_addr = FW'(CW'(in_channel_index)) * FW'(MAX_SECTIONS) + FW'(wsec);
  assign rff_addr = FW'(ch_idx) * FW'(MAX_SECTIONS) + FW'(sec_idx);
  assign clr_low = 32'(clr_idx) < MAX_SECTIONS;

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      ff0_mem[clr_idx] <= '0;
      ff1_mem[clr_idx] <= '0;
      ff2_mem[clr_idx] <= '0;
    end else if (cmd.wr_coef && sec_ok && ch_ok) begin
      if (in_coef_select == SEL_A0) ff0_mem[wff_addr] <= in_coef_value;
      if (in_coef_select == SEL_A1) ff1_mem[wff_addr] <= in_coef_value;
      if (in_coef_select == SEL_A2) ff2_mem[wff_addr] <= in_coef_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr && clr_low) begin
      fb1_mem[SW'(clr_idx)] <= '0;
      fb2_mem[SW'(clr_idx)] <= '0;
    end else if (cmd.wr_coef && sec_ok) begin
      if (in_coef_select == SEL_B1) fb1_mem[wsec] <= in_coef_value;
      if (in_coef_select == SEL_B2) fb2_mem[wsec] <= in_coef_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr && clr_low) begin
      d1_mem[SW'(clr_idx)] <= '0;
      d2_mem[SW'(clr_idx)] <= '0;
    end else if (cmd.upd) begin
      d1_mem[sec_idx] <= w_r;
      d2_mem[sec_idx] <= d1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_sec) begin
      d1_r <= d1_mem[sec_idx];
      d2_r <= d2_mem[sec_idx];
      b1_r <= fb1_mem[sec_idx];
      b2_r <= fb2_mem[sec_idx];
    end
    if (cmd.ff_rd) begin
      a0_r <= ff0_mem[rff_addr];
      a1_r <= ff1_mem[rff_addr];
      a2_r <= ff2_mem[rff_addr];
      ffch_r <= ch_idx;
    end
  end

  always_comb begin
    case (cmd.mul_op)
      MUL_B1D1: begin mul_a = b1_r; mul_b = d1_r; end
      MUL_B2D2: begin mul_a = b2_r; mul_b = d2_r; end
      MUL_A0W:  begin mul_a = a0_r; mul_b = w_r;  end
      MUL_A1D1: begin mul_a = a1_r; mul_b = d1_r; end
      MUL_A2D2: begin mul_a = a2_r; mul_b = d2_r; end
      default:  begin mul_a = '0;   mul_b = '0;   end
    endcase
  end

  assign rnd = prod_r + HALF;
  assign term = TERM_BITS'(rnd >>> COEF_FRAC);

  always_ff @(posedge clk) begin
    prod_r <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
    pop_r <= cmd.mul_op;
    pch_r <= ffch_r;
    if (cmd.start) x_r <= in_sample;
    if (cmd.rd_sec) begin
      wacc_r <= WACC_BITS'(x_r);
    end else if (pop_r == MUL_B1D1 || pop_r == MUL_B2D2) begin
      wacc_r <= wacc_r - WACC_BITS'(term);
    end
    if (cmd.wsat) begin
      if (wacc_r > W_MAX) w_r <= STATE_BITS'(W_MAX);
      else if (wacc_r < W_MIN) w_r <= STATE_BITS'(W_MIN);
      else w_r <= STATE_BITS'(wacc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < MAX_CHANNELS; i++) acc_r[i] <= '0;
    end else if (pop_r == MUL_A0W || pop_r == MUL_A1D1 || pop_r == MUL_A2D2) begin
      acc_r[pch_r] <= acc_r[pch_r] + ACC_BITS'(term);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_channel_r <= 3'(ch_idx);
      out_last_r <= cmd.out_last;
      if (acc_r[ch_idx] > Y_MAX) out_sample_r <= SAMPLE_BITS'(Y_MAX);
      else if (acc_r[ch_idx] < Y_MIN) out_sample_r <= SAMPLE_BITS'(Y_MIN);
      else out_sample_r <= SAMPLE_BITS'(acc_r[ch_idx]);
    end
  end

  assign out_channel = out_channel_r;
  assign out_sample = out_sample_r;
  assign out_last_channel = out_last_r;

endmodule

// ----- rtl/core/bqb_ctrl.sv -----
// Controller: clearing sweep, section and channel sequencing, result handshake.
`timescale 1ns / 1ps
module bqb_ctrl
  import bqb_pkg::*;
#(
  parameter int MAX_SECTIONS = MAX_SECTIONS_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  localparam int SW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1,
  localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int SCW = $clog2(MAX_SECTIONS + 1),
  localparam int CCW = $clog2(MAX_CHANNELS + 1),
  localparam int FF_DEPTH = MAX_SECTIONS * MAX_CHANNELS,
  localparam int FW = (FF_DEPTH > 1) ? $clog2(FF_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_command,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  logic [6:0]    sections_cfg,
  input  logic [3:0]    channels_cfg,
  output dp_cmd_t       cmd,
  output logic [FW-1:0] clr_idx,
  output logic [SW-1:0] sec_idx,
  output logic [CW-1:0] ch_idx
);

  state_t         state_r, state_nxt;
  logic [SCW-1:0] sec_r, sec_nxt, nsec, sec_inc;
  logic [CCW-1:0] ch_r, ch_nxt, nch, ch_inc;
  logic [FW-1:0]  clr_r, clr_nxt;

  assign nsec = (32'(sections_cfg) > MAX_SECTIONS) ? SCW'(MAX_SECTIONS) : SCW'(sections_cfg);
  assign nch = (32'(channels_cfg) > MAX_CHANNELS) ? CCW'(MAX_CHANNELS) : CCW'(channels_cfg);
  assign sec_inc = sec_r + SCW'(1);
  assign ch_inc = ch_r + CCW'(1);
  assign clr_idx = clr_r;
  assign sec_idx = sec_r[SW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      sec_r <= '0;
      ch_r <= '0;
      clr_r <= '0;
    end else begin
      state_r <= state_nxt;
      sec_r <= sec_nxt;
      ch_r <= ch_nxt;
      clr_r <= clr_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sec_nxt = sec_r;
    ch_nxt = ch_r;
    clr_nxt = clr_r;
    cmd = '0;
    cmd.mul_op = MUL_NONE;
    in_ready = 1'b0;
    out_valid = 1'b0;
    ch_idx = ch_r[CW-1:0];
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        clr_nxt = clr_r + FW'(1);
        if (clr_r == FW'(FF_DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_command == CMD_WRITE) begin
            cmd.wr_coef = 1'b1;
          end else begin
            cmd.start = 1'b1;
            sec_nxt = '0;
            ch_nxt = '0;
            if (nsec != '0) state_nxt = ST_READ;
            else if (nch != '0) state_nxt = ST_OLOAD;
          end
        end
      end
      ST_READ: begin
        cmd.rd_sec = 1'b1;
        state_nxt = ST_FB1;
      end
      ST_FB1: begin
        cmd.mul_op = MUL_B1D1;
        state_nxt = ST_FB2;
      end
      ST_FB2: begin
        cmd.mul_op = MUL_B2D2;
        state_nxt = ST_FBW;
      end
      ST_FBW: state_nxt = ST_WSAT;
      ST_WSAT: begin
        cmd.wsat = 1'b1;
        cmd.ff_rd = 1'b1;
        state_nxt = (nch == '0) ? ST_UPD : ST_FF0;
      end
      ST_FF0: begin
        cmd.mul_op = MUL_A0W;
        state_nxt = ST_FF1;
      end
      ST_FF1: begin
        cmd.mul_op = MUL_A1D1;
        state_nxt = ST_FF2;
      end
      ST_FF2: begin
        cmd.mul_op = MUL_A2D2;
        if (ch_inc == nch) begin
          ch_nxt = '0;
          state_nxt = ST_UPD;
        end else begin
          ch_idx = ch_inc[CW-1:0];
          cmd.ff_rd = 1'b1;
          ch_nxt = ch_inc;
          state_nxt = ST_FF0;
        end
      end
      ST_UPD: begin
        cmd.upd = 1'b1;
        sec_nxt = sec_inc;
        ch_nxt = '0;
        if (sec_inc == nsec) state_nxt = (nch == '0) ? ST_IDLE : ST_OLOAD;
        else state_nxt = ST_READ;
      end
      ST_OLOAD: begin
        cmd.out_load = 1'b1;
        cmd.out_last = (ch_inc == nch);
        state_nxt = ST_OWAIT;
      end
      ST_OWAIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (ch_inc == nch) begin
            ch_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            ch_nxt = ch_inc;
            state_nxt = ST_OLOAD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result word is pending");
  a_sec_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (sec_r <= nsec) || (state_r == ST_IDLE) || (state_r == ST_CLEAR))
    else $error("section counter past section count");
  a_ch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ch_r < CCW'(MAX_CHANNELS))
    else $error("channel counter out of range");
  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OWAIT && out_ready && ch_inc == nch) |=> in_ready)
    else $error("not idle after last result word");
`endif

endmodule

// ----- rtl/core/biquad_bank_multi_output_unit.sv -----
// Top level: configuration registers, controller and datapath.
// Clearing pass after reset: MAX_SECTIONS*MAX_CHANNELS entries (512 by default), no input taken.
// Coefficient write word: taken while idle. Sample word: every section is computed through the one
// shared multiplier (S sections, C channels in use), then one result word per channel, held until out_ready.
// Reset is synchronous, active low; registers reset to one section and one channel,
// and the clearing pass zeroes all coefficients and delay states.
`timescale 1ns / 1ps
module biquad_bank_multi_output_unit
  import bqb_pkg::*;
#(
  parameter int MAX_SECTIONS = MAX_SECTIONS_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic [2:0]                    in_coef_select,
  input  logic [5:0]                    in_section_index,
  input  logic [2:0]                    in_channel_index,
  input  logic signed [COEF_BITS-1:0]   in_coef_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_channel,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_last_channel,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [2:0]                    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int SW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int FF_DEPTH = MAX_SECTIONS * MAX_CHANNELS;
  localparam int FW = (FF_DEPTH > 1) ? $clog2(FF_DEPTH) : 1;

  logic [6:0]    sections_r;
  logic [3:0]    channels_r;
  logic          cfg_wr;
  dp_cmd_t       cmd;
  logic [FW-1:0] clr_idx;
  logic [SW-1:0] sec_idx;
  logic [CW-1:0] ch_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sections_r <= 7'd1;
      channels_r <= 4'd1;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_SECTIONS) sections_r <= cfg_pwdata[6:0];
      if (cfg_paddr[2] == REG_CHANNELS) channels_r <= cfg_pwdata[3:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_SECTIONS) ? {25'd0, sections_r}
                                                     : {28'd0, channels_r};

  bqb_ctrl #(
    .MAX_SECTIONS(MAX_SECTIONS),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_command  (in_command),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sections_cfg(sections_r),
    .channels_cfg(channels_r),
    .cmd         (cmd),
    .clr_idx     (clr_idx),
    .sec_idx     (sec_idx),
    .ch_idx      (ch_idx)
  );

  bqb_datapath #(
    .MAX_SECTIONS(MAX_SECTIONS),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .clr_idx         (clr_idx),
    .sec_idx         (sec_idx),
    .ch_idx          (ch_idx),
    .in_sample       (in_sample),
    .in_coef_select  (in_coef_select),
    .in_section_index(in_section_index),
    .in_channel_index(in_channel_index),
    .in_coef_value   (in_coef_value),
    .out_channel     (out_channel),
    .out_sample      (out_sample),
    .out_last_channel(out_last_channel)
  );

endmodule
